[rtl/lst_pkg.sv]
// lst_pkg: shared constants, codes and control structs of the lifecycle state table
// no dependencies; imported by every module of the block
package lst_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned KEY_BITS      = 32;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned GRP_SIZE      = 8;
  localparam int unsigned SUB_W         = $clog2(GRP_SIZE);
  localparam int unsigned GRP_NUM       = (TABLE_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [2:0] {
    REQ_QUERY    = 3'd0,
    REQ_CREATE   = 3'd1,
    REQ_ACTIVATE = 3'd2,
    REQ_RETIRE   = 3'd3,
    REQ_POP      = 3'd4,
    REQ_ERASE    = 3'd5
  } lst_req_e;

  typedef enum logic [2:0] {
    PH_ABSENT    = 3'd0,
    PH_CREATING  = 3'd1,
    PH_ACTIVE    = 3'd2,
    PH_WAITING   = 3'd3,
    PH_RELEASING = 3'd4
  } lst_phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_FULL    = 2'd2
  } lst_status_e;

  typedef struct packed {
    logic             hit;
    lst_phase_e       phase;
    logic [IDX_W-1:0] slot;
    logic             free_ok;
  } lst_tbl_stat_t;

  typedef struct packed {
    logic             create;
    logic             set_hit;
    lst_phase_e       new_phase;
    logic             clear_hit;
    logic             release_en;
    logic [IDX_W-1:0] release_slot;
  } lst_tbl_upd_t;

  typedef struct packed {
    logic [IDX_W-1:0]    slot;
    logic [KEY_BITS-1:0] key;
  } lst_q_item_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    lst_q_item_t item;
  } lst_q_ctl_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    lst_q_item_t head;
  } lst_q_stat_t;

endpackage

[rtl/lst_entry_table.sv]
// lst_entry_table: resident key store with parallel key match, phase per entry
// and lowest free slot search; depends on lst_pkg
module lst_entry_table
  import lst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KEY_BITS-1:0] key_i,
  input  lst_tbl_upd_t        upd_i,
  output lst_tbl_stat_t       stat_o
);

  logic [TABLE_ENTRIES-1:0] used_q;
  logic [KEY_BITS-1:0]      tag_q   [TABLE_ENTRIES];
  lst_phase_e               phase_q [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] hit;
  logic [2:0]               phase_bits;
  logic [IDX_W-1:0]         hit_slot;
  logic [GRP_NUM-1:0]       grp_free;
  logic [SUB_W-1:0]         grp_idx [GRP_NUM];
  logic                     free_ok;
  logic [IDX_W-1:0]         free_idx;

  // match lines and one-hot read of the matching entry
  always_comb begin
    phase_bits = '0;
    hit_slot   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i]     = used_q[i] && (tag_q[i] == key_i);
      phase_bits = phase_bits | ({3{hit[i]}} & phase_q[i]);
      hit_slot   = hit_slot | (hit[i] ? IDX_W'(i) : '0);
    end
  end

  // lowest free slot, searched in groups of eight
  always_comb begin
    for (int g = 0; g < GRP_NUM; g++) begin
      grp_free[g] = 1'b0;
      grp_idx[g]  = '0;
      for (int k = GRP_SIZE - 1; k >= 0; k--) begin
        if ((g * GRP_SIZE + k < TABLE_ENTRIES) && !used_q[g * GRP_SIZE + k]) begin
          grp_free[g] = 1'b1;
          grp_idx[g]  = SUB_W'(k);
        end
      end
    end
    free_ok  = 1'b0;
    free_idx = '0;
    for (int g = GRP_NUM - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(g * GRP_SIZE + int'(grp_idx[g]));
      end
    end
  end

  assign stat_o.hit     = |hit;
  assign stat_o.phase   = lst_phase_e'(phase_bits);
  assign stat_o.slot    = hit_slot;
  assign stat_o.free_ok = free_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (upd_i.create && (free_idx == IDX_W'(i))) begin
          used_q[i] <= 1'b1;
        end else if (upd_i.clear_hit && hit[i]) begin
          used_q[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (upd_i.create && (free_idx == IDX_W'(i))) begin
        tag_q[i]   <= key_i;
        phase_q[i] <= PH_CREATING;
      end else if (upd_i.set_hit && hit[i]) begin
        phase_q[i] <= upd_i.new_phase;
      end else if (upd_i.release_en && (upd_i.release_slot == IDX_W'(i))) begin
        phase_q[i] <= PH_RELEASING;
      end
    end
  end

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one entry matches the key");

endmodule

[rtl/lst_release_queue.sv]
// lst_release_queue: in-order queue of retired entries (slot and key)
// memory with registered read of the head; depends on lst_pkg
module lst_release_queue
  import lst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lst_q_ctl_t  ctl_i,
  output lst_q_stat_t stat_o
);

  lst_q_item_t      mem [TABLE_ENTRIES];
  lst_q_item_t      head_item_q;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.push) begin
      tail_d  = (tail_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : tail_q + IDX_W'(1);
      count_d = count_q + CNT_W'(1);
    end else if (ctl_i.pop) begin
      head_d  = (head_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : head_q + IDX_W'(1);
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // head prefetch with bypass of a write to the next head address
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= ctl_i.item;
    end
    if (ctl_i.push && (tail_q == head_d)) begin
      head_item_q <= ctl_i.item;
    end else begin
      head_item_q <= mem[head_d];
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_W'(TABLE_ENTRIES));
  assign stat_o.head  = head_item_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_ENTRIES))
    else $error("release queue count beyond capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> (count_q != '0) && !ctl_i.push)
    else $error("pop from empty queue or pop with push");

endmodule

[rtl/lifecycle_state_table.sv]
// lifecycle_state_table: one request per cycle, one result per request; each
// passes the request and result registers. The result stands on the ports for
// one cycle and cannot be held off. busy_o stays low: a request register feeds
// a single pass of key match, free slot search and queue update into a result
// register, so a new transaction is taken every cycle. Entry valid bits and
// queue pointers clear at reset, no clearing pass is needed.
module lifecycle_state_table
  import lst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] key_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [2:0]  state_code_o,
  output logic [31:0] key_out_o,
  output logic        key_valid_o
);

  logic                valid_q;
  logic [2:0]          req_q;
  logic [KEY_BITS-1:0] key_q;

  lst_tbl_stat_t tbl_stat;
  lst_tbl_upd_t  tbl_upd;
  lst_q_stat_t   q_stat;
  lst_q_ctl_t    q_ctl;

  lst_status_e         status_d;
  lst_phase_e          code_d;
  logic [KEY_BITS-1:0] kout_d;
  logic                kval_d;
  lst_phase_e          cur;

  logic                done_q;
  lst_status_e         status_q;
  lst_phase_e          code_q;
  logic [KEY_BITS-1:0] kout_q;
  logic                kval_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_type_i;
    key_q <= key_i[KEY_BITS-1:0];
  end

  lst_entry_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_q),
    .upd_i  (tbl_upd),
    .stat_o (tbl_stat)
  );

  lst_release_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (q_ctl),
    .stat_o (q_stat)
  );

  assign cur = tbl_stat.hit ? tbl_stat.phase : PH_ABSENT;

  always_comb begin
    status_d             = ST_OK;
    code_d               = PH_ABSENT;
    kout_d               = '0;
    kval_d               = 1'b0;
    tbl_upd              = '0;
    tbl_upd.new_phase    = PH_ABSENT;
    tbl_upd.release_slot = q_stat.head.slot;
    q_ctl                = '0;
    q_ctl.item.slot      = tbl_stat.slot;
    q_ctl.item.key       = key_q;
    case (lst_req_e'(req_q))
      REQ_QUERY: begin
        code_d = cur;
      end
      REQ_CREATE: begin
        if (tbl_stat.hit) begin
          status_d = ST_ILLEGAL;
          code_d   = cur;
        end else if (!tbl_stat.free_ok) begin
          status_d = ST_FULL;
        end else begin
          tbl_upd.create = valid_q;
          code_d         = PH_CREATING;
        end
      end
      REQ_ACTIVATE: begin
        if (tbl_stat.hit && (cur == PH_CREATING)) begin
          tbl_upd.set_hit   = valid_q;
          tbl_upd.new_phase = PH_ACTIVE;
          code_d            = PH_ACTIVE;
        end else begin
          status_d = ST_ILLEGAL;
          code_d   = cur;
        end
      end
      REQ_RETIRE: begin
        if (tbl_stat.hit && (cur == PH_ACTIVE) && !q_stat.full) begin
          tbl_upd.set_hit   = valid_q;
          tbl_upd.new_phase = PH_WAITING;
          q_ctl.push        = valid_q;
          code_d            = PH_WAITING;
        end else begin
          status_d = ST_ILLEGAL;
          code_d   = cur;
        end
      end
      REQ_POP: begin
        if (!q_stat.empty) begin
          q_ctl.pop          = valid_q;
          tbl_upd.release_en = valid_q;
          code_d             = PH_RELEASING;
          kout_d             = q_stat.head.key;
          kval_d             = 1'b1;
        end
      end
      REQ_ERASE: begin
        if (tbl_stat.hit && (cur == PH_RELEASING)) begin
          tbl_upd.clear_hit = valid_q;
        end else begin
          status_d = ST_ILLEGAL;
          code_d   = cur;
        end
      end
      default: begin
        status_d = ST_ILLEGAL;
        code_d   = cur;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    code_q   <= code_d;
    kout_q   <= kout_d;
    kval_q   <= kval_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign state_code_o = code_q;
  assign key_out_o    = 32'(kout_q);
  assign key_valid_o  = kval_q;

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && key_valid_o |-> (status_o == ST_OK) && (state_code_o == PH_RELEASING))
    else $error("returned key without releasing phase");

  a_full_on_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (status_d == ST_FULL) |-> (req_q == REQ_CREATE) && !tbl_stat.hit)
    else $error("table full status outside a create of a new key");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (req_q == REQ_POP) && q_stat.empty |=> done_o && !key_valid_o)
    else $error("pop of an empty queue returned a key");

  a_single_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tbl_upd.create, tbl_upd.set_hit, tbl_upd.clear_hit, tbl_upd.release_en}))
    else $error("more than one table update in a cycle");

endmodule

[test/lst_checker.sv]
`timescale 1ns / 100ps
// lst_checker: keeps its own lifecycle table and release queue, predicts the
// result of every accepted transaction and compares it with done_o results
// depends on lst_pkg for the request, phase and status codes
module lst_checker
  import lst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] key_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [2:0]  state_code_i,
  input  logic [31:0] key_out_i,
  input  logic        key_valid_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o,
  output int          full_o,
  output int          released_o
);

  typedef struct packed {
    lst_status_e status;
    lst_phase_e  phase;
    logic [31:0] key_out;
    logic        key_valid;
  } lst_result_t;

  logic        slot_used  [TABLE_ENTRIES];
  logic [31:0] slot_key   [TABLE_ENTRIES];
  lst_phase_e  slot_phase [TABLE_ENTRIES];
  int          release_order[$];
  lst_result_t pending_results[$];

  task automatic table_step(input logic [2:0] rq, input logic [31:0] k,
                            output lst_result_t r);
    int         hit;
    int         free;
    int         s;
    lst_phase_e cur;
    hit  = -1;
    free = -1;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == k) hit = i;
      if (!slot_used[i]) free = i;
    end
    cur = (hit >= 0) ? slot_phase[hit] : PH_ABSENT;
    r.status    = ST_OK;
    r.phase     = cur;
    r.key_out   = '0;
    r.key_valid = 1'b0;
    case (rq)
      REQ_QUERY: ;
      REQ_CREATE: begin
        if (hit >= 0) begin
          r.status = ST_ILLEGAL;
        end else if (free < 0) begin
          r.status = ST_FULL;
          r.phase  = PH_ABSENT;
        end else begin
          slot_used[free]  = 1'b1;
          slot_key[free]   = k;
          slot_phase[free] = PH_CREATING;
          r.phase          = PH_CREATING;
        end
      end
      REQ_ACTIVATE: begin
        if (hit >= 0 && cur == PH_CREATING) begin
          slot_phase[hit] = PH_ACTIVE;
          r.phase         = PH_ACTIVE;
        end else begin
          r.status = ST_ILLEGAL;
        end
      end
      REQ_RETIRE: begin
        if (hit >= 0 && cur == PH_ACTIVE) begin
          slot_phase[hit] = PH_WAITING;
          release_order.insert(release_order.size(), hit);
          r.phase = PH_WAITING;
        end else begin
          r.status = ST_ILLEGAL;
        end
      end
      REQ_POP: begin
        r.phase = PH_ABSENT;
        if (release_order.size() != 0) begin
          s             = release_order[0];
          release_order.delete(0);
          slot_phase[s] = PH_RELEASING;
          r.phase       = PH_RELEASING;
          r.key_out     = slot_key[s];
          r.key_valid   = 1'b1;
        end
      end
      REQ_ERASE: begin
        if (hit >= 0 && cur == PH_RELEASING) begin
          slot_used[hit] = 1'b0;
          r.phase        = PH_ABSENT;
        end else begin
          r.status = ST_ILLEGAL;
        end
      end
      default: r.status = ST_ILLEGAL;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lst_result_t want;
    lst_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      release_order.delete();
      pending_results.delete();
      errors_o   = 0;
      pending_o  = 0;
      checked_o  = 0;
      full_o     = 0;
      released_o = 0;
    end else begin
      if (done_i) begin
        got = {status_i, state_code_i, key_out_i, key_valid_i};
        if (pending_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 30)
            $display("%0t: result with no transaction waiting: status %0d state %0d key %h/%0b",
                     $time, status_i, state_code_i, key_out_i, key_valid_i);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          checked_o++;
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 30)
              $display("%0t: mismatch exp status %0d state %0d key %h/%0b, got %0d %0d %h/%0b",
                       $time, want.status, want.phase, want.key_out, want.key_valid,
                       status_i, state_code_i, key_out_i, key_valid_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        table_step(req_type_i, key_i, want);
        if (want.status == ST_FULL) full_o++;
        if (want.key_valid) released_o++;
        pending_results.insert(pending_results.size(), want);
      end
      pending_o = pending_results.size();
    end
  end

endmodule

[test/tb_lifecycle_state_table.sv]
`timescale 1ns / 100ps
// tb_lifecycle_state_table: drives directed and random request streams with
// random gaps into lifecycle_state_table and reports the verdict
// depends on lst_pkg, the block and lst_checker
module tb_lifecycle_state_table;
  import lst_pkg::*;

  localparam int NUM_REQS   = 1050;
  localparam int POOL_SIZE  = 96;
  localparam int IDLE_LIMIT = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  req_type_i;
  logic [31:0] key_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [2:0]  state_code_o;
  logic [31:0] key_out_o;
  logic        key_valid_o;

  int          errors;
  int          pending;
  int          checked;
  int          full_seen;
  int          released;
  int          n_sent;
  int          idle_cycles = 0;
  int          burst_left;
  logic [31:0] key_pool[POOL_SIZE];
  logic [31:0] popped_keys[$];

  lifecycle_state_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .state_code_o(state_code_o),
    .key_out_o   (key_out_o),
    .key_valid_o (key_valid_o)
  );

  lst_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .done_i      (done_o),
    .status_i    (status_o),
    .state_code_i(state_code_o),
    .key_out_i   (key_out_o),
    .key_valid_i (key_valid_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_o      (full_seen),
    .released_o  (released)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // keys handed back by pops, used to aim erase transactions
  always @(posedge clk_i) begin
    if (done_o && key_valid_o) popped_keys.insert(popped_keys.size(), key_out_o);
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] any_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic idle_gap();
    int n;
    int r;
    n = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) n = 0;
      else if (r < 88) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 30);
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 60);
    end
    if (n > 0) begin
      start_i    <= 1'b0;
      req_type_i <= 3'($urandom);
      key_i      <= $urandom;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // called at a rising edge; returns after the edge that accepts the transaction and any idle gap
  task automatic send_req(input logic [2:0] rq, input logic [31:0] k);
    start_i    <= 1'b1;
    req_type_i <= rq;
    key_i      <= k;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    n_sent++;
    idle_gap();
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic erase_popped();
    logic [31:0] k;
    if (popped_keys.size() != 0) begin
      k = popped_keys[0];
      popped_keys.delete(0);
      send_req(REQ_ERASE, k);
    end
  endtask

  initial begin
    logic [31:0] k;
    int          mode;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_type_i  = '0;
    key_i       = '0;
    burst_left  = 0;
    n_sent      = 0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, wrong phases, unused codes, extreme keys
    send_req(REQ_POP, $urandom);
    send_req(REQ_QUERY, 32'h0);
    send_req(REQ_ERASE, 32'h0);
    send_req(REQ_CREATE, 32'h0);
    send_req(REQ_CREATE, 32'h0);
    send_req(REQ_RETIRE, 32'h0);
    send_req(REQ_ACTIVATE, 32'h0);
    send_req(REQ_ACTIVATE, 32'h0);
    send_req(REQ_ERASE, 32'h0);
    send_req(REQ_RETIRE, 32'h0);
    send_req(REQ_RETIRE, 32'h0);
    send_req(REQ_CREATE, 32'hFFFF_FFFF);
    send_req(REQ_ACTIVATE, 32'hFFFF_FFFF);
    send_req(REQ_RETIRE, 32'hFFFF_FFFF);
    send_req(REQ_POP, 32'hFFFF_FFFF);
    send_req(REQ_QUERY, 32'h0);
    send_req(3'd6, 32'h0);
    send_req(3'd7, 32'hFFFF_FFFF);
    send_req(REQ_POP, 32'h0);
    send_req(REQ_ERASE, 32'h0);
    send_req(REQ_ERASE, 32'hFFFF_FFFF);
    send_req(REQ_POP, 32'hFFFF_FFFF);
    send_req(REQ_QUERY, 32'hFFFF_FFFF);
    popped_keys.delete();

    // fill past capacity so creates run into a full table
    for (int i = 2; i < 2 + TABLE_ENTRIES + 2; i++) send_req(REQ_CREATE, key_pool[i]);

    while (n_sent < NUM_REQS) begin
      if (n_sent >= NUM_REQS / 2 && n_sent < NUM_REQS / 2 + 8) wait_drained();
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_req(REQ_CREATE, k);
        send_req(REQ_ACTIVATE, k);
        send_req(REQ_RETIRE, k);
        send_req(REQ_POP, $urandom);
        erase_popped();
      end else if (mode == 6) begin
        repeat (6) send_req(REQ_CREATE, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else if (mode == 7) begin
        repeat (3) send_req(REQ_POP, $urandom);
        repeat (3) erase_popped();
      end else begin
        repeat ($urandom_range(1, 4)) send_req(3'($urandom_range(0, 7)), any_key());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results: %0d table-full refusals, %0d keys released",
             n_sent, checked, full_seen, released);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
